/* rtl/core/sha256_pkg.sv */
// SHA-256 stream hasher shared constants, types and round functions.
`default_nettype none
package sha256_pkg;

  localparam int unsigned CntW = 29;

  typedef struct packed {
    logic load_byte;   // merge byte into block at current position
    logic load_pad;    // merge 0x80 pad byte at current position
    logic load_len;    // write length into words 14 and 15
    logic start;       // begin a compression
    logic clr_msg;     // restore chain, clear count and block
  } sha_cmd_t;

  typedef struct packed {
    logic       busy;      // compression in progress
    logic       blk_full;  // count low bits at 63, next byte fills the block
    logic       pad_extra; // pending bytes >= 56
  } sha_sts_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    begin
      case (i)
        3'd0: r = 32'h6a09e667;
        3'd1: r = 32'hbb67ae85;
        3'd2: r = 32'h3c6ef372;
        3'd3: r = 32'ha54ff53a;
        3'd4: r = 32'h510e527f;
        3'd5: r = 32'h9b05688c;
        3'd6: r = 32'h1f83d9ab;
        default: r = 32'h5be0cd19;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    begin
      k = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[t];
    end
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage
`default_nettype wire

/* rtl/core/sha256_datapath.sv */
// SHA-256 datapath: block buffer, message schedule, round unit and chain value.
`default_nettype none
module sha256_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sha256_pkg::sha_cmd_t cmd_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic [2:0]          dsel_i,
  output sha256_pkg::sha_sts_t     sts_o,
  output logic [31:0]              digest_o
);
  import sha256_pkg::*;

  logic [31:0]     w_q [16];
  logic [31:0]     w_d [16];
  logic [31:0]     h_q [8];
  logic [31:0]     h_d [8];
  logic [31:0]     v_q [8];
  logic [31:0]     v_d [8];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [6:0]      rnd_q, rnd_d;
  logic            busy_q, busy_d;
  logic [5:0]      pos;
  logic [31:0]     ins;
  logic [3:0]      widx;
  logic [31:0]     s0, s1, wnew, t1, t2, big0, big1, chs, maj;

  assign pos  = cnt_q[5:0];
  assign widx = pos[5:2];
  assign ins  = {cmd_i.load_pad ? 8'h80 : byte_i, 24'd0} >> {pos[1:0], 3'd0};

  assign s0   = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1   = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = s1 + w_q[9] + s0 + w_q[0];
  assign big1 = ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25);
  assign chs  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1   = v_q[7] + big1 + chs + round_k(rnd_q[5:0]) + w_q[0];
  assign big0 = ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22);
  assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = big0 + maj;

  always_comb begin
    w_d    = w_q;
    h_d    = h_q;
    v_d    = v_q;
    cnt_d  = cnt_q;
    rnd_d  = rnd_q;
    busy_d = busy_q;
    if (cmd_i.load_byte || cmd_i.load_pad) begin
      w_d[widx] = w_q[widx] | ins;
    end
    if (cmd_i.load_byte) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.load_len) begin
      w_d[14] = '0;
      w_d[15] = {cnt_q, 3'd0};
    end
    if (cmd_i.start) begin
      busy_d = 1'b1;
      rnd_d  = '0;
      v_d    = h_q;
    end
    if (busy_q) begin
      // shift the schedule window one word per round
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = wnew;
      v_d[7] = v_q[6]; v_d[6] = v_q[5]; v_d[5] = v_q[4]; v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2]; v_d[2] = v_q[1]; v_d[1] = v_q[0]; v_d[0] = t1 + t2;
      rnd_d = rnd_q + 1'b1;
      if (rnd_q == 7'd63) begin
        busy_d = 1'b0;
        rnd_d  = '0;
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_d[i];
          w_d[i] = '0;
          w_d[i+8] = '0;
        end
      end
    end
    if (cmd_i.clr_msg) begin
      for (int i = 0; i < 8; i++) begin
        h_d[i] = init_hash(3'(i));
      end
      for (int i = 0; i < 16; i++) begin
        w_d[i] = '0;
      end
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rnd_q  <= '0;
      busy_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= init_hash(3'(i));
        v_q[i] <= '0;
      end
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= '0;
      end
    end else begin
      cnt_q  <= cnt_d;
      rnd_q  <= rnd_d;
      busy_q <= busy_d;
      h_q    <= h_d;
      v_q    <= v_d;
      w_q    <= w_d;
    end
  end

  assign sts_o.busy      = busy_q;
  assign sts_o.blk_full  = (pos == 6'd63);
  assign sts_o.pad_extra = pos >= 6'd56;
  assign digest_o        = h_q[dsel_i];

  a_rnd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> rnd_q == '0) else $error("round counter moved while idle");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !(cmd_i.load_byte || cmd_i.load_pad || cmd_i.load_len))
    else $error("block written during compression");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && rnd_q == 7'd63) |=> !busy_q) else $error("compression overran");
endmodule
`default_nettype wire

/* rtl/core/sha256_ctrl.sv */
// SHA-256 controller: input handshake, padding sequence and digest output.
`default_nettype none
module sha256_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 has_i,
  input  wire logic                 last_i,
  output sha256_pkg::sha_cmd_t      cmd_o,
  input  wire sha256_pkg::sha_sts_t sts_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                dsel_o
);
  import sha256_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SBlk   = 3'd1;
  localparam logic [2:0] SPad   = 3'd2;
  localparam logic [2:0] SExtra = 3'd3;
  localparam logic [2:0] SFinal = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0] st_q, st_d;
  logic       last_q, last_d;
  logic [2:0] idx_q, idx_d;
  logic       acc;

  assign in_ready_o  = (st_q == SIdle);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = (st_q == SOut);
  assign dsel_o      = idx_q;

  always_comb begin
    st_d   = st_q;
    last_d = last_q;
    idx_d  = idx_q;
    cmd_o  = '0;
    case (st_q)
      SIdle: begin
        if (acc) begin
          last_d = last_i;
          cmd_o.load_byte = has_i;
          if (has_i && sts_i.blk_full) begin
            cmd_o.start = 1'b1;
            st_d = SBlk;
          end else if (last_i) begin
            st_d = SPad;
          end
        end
      end
      SBlk: begin
        if (!sts_i.busy) begin
          st_d = last_q ? SPad : SIdle;
        end
      end
      SPad: begin
        cmd_o.load_pad = 1'b1;
        if (sts_i.pad_extra) begin
          cmd_o.start = 1'b1;
          st_d = SExtra;
        end else begin
          cmd_o.load_len = 1'b1;
          cmd_o.start = 1'b1;
          st_d = SFinal;
        end
      end
      SExtra: begin
        if (!sts_i.busy) begin
          cmd_o.load_len = 1'b1;
          cmd_o.start = 1'b1;
          st_d = SFinal;
        end
      end
      SFinal: begin
        if (!sts_i.busy) begin
          idx_d = '0;
          st_d = SOut;
        end
      end
      SOut: begin
        if (out_ready_i) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 3'd7) begin
            cmd_o.clr_msg = 1'b1;
            st_d = SIdle;
          end
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SIdle;
      last_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      st_q   <= st_d;
      last_q <= last_d;
      idx_q  <= idx_d;
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> !sts_i.busy) else $error("start while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(idx_q))
    else $error("digest index moved while stalled");
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_msg |-> st_q == SOut && idx_q == 3'd7) else $error("stray clear");
endmodule
`default_nettype wire

/* rtl/core/sha256_stream_hasher.sv */
// SHA-256 stream hasher top level: byte stream in, eight digest words out.
// Bytes enter one per transfer, most significant byte first within each 32-bit
// word; tuser[0] says whether tdata carries a byte and tlast ends the message.
// The 64th byte of a block starts the compression, which runs one round per
// cycle in a single shared round unit, and input is held off until it ends.
// At the end of a message the controller merges the 0x80 pad, runs one extra
// compression when 56 or more bytes are pending, writes the 32-bit bit length
// (the upper length word is zero and the count wraps modulo 2^32) and runs the
// final block, then presents digest words 0..7 on the master side, tlast on
// word 7. Input is held off until the last digest word transfers. A message
// of no bytes gives the empty-message digest.
`default_nettype none
module sha256_stream_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  wire logic        s_axis_tuser,   // [0] has_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic             m_axis_tlast    // last_word
);
  import sha256_pkg::*;

  sha_cmd_t   cmd;
  sha_sts_t   sts;
  logic [2:0] dsel;
  logic [31:0] digest;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .has_i       (s_axis_tuser),
    .last_i      (s_axis_tlast),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .dsel_o      (dsel)
  );

  sha256_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .byte_i   (s_axis_tdata),
    .dsel_i   (dsel),
    .sts_o    (sts),
    .digest_o (digest)
  );

  assign m_axis_tdata = {5'd0, dsel, digest};
  assign m_axis_tlast = (dsel == 3'd7);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input open during output");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("no return to idle after digest");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("digest changed while stalled");
endmodule
`default_nettype wire

/* verif/sha256_stream_hasher_chk.sv */
// Checker for the SHA-256 stream hasher: digest predictor and output compare.
module sha256_stream_hasher_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          digest_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] HashIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  logic [31:0]  chain_q [8];
  logic [31:0]  block_q [16];
  logic [28:0]  byte_cnt_q;
  digest_word_t digest_exp_q [$];
  int           fail_q;

  assign fail_count_o     = fail_q;
  assign digest_pending_o = digest_exp_q.size();

  function automatic logic [31:0] rotr(logic [31:0] v, int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // Fold the current block into the chain and clear the block.
  task automatic fold_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++) w[t] = block_q[t];
    for (int t = 16; t < 64; t++) begin
      w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    end
    v = chain_q;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int t = 0; t < 8; t++) chain_q[t] += v[t];
    for (int t = 0; t < 16; t++) block_q[t] = '0;
  endtask

  task automatic merge_byte(logic [5:0] pos, logic [7:0] b);
    block_q[pos[5:2]] |= 32'(b) << (24 - 8 * pos[1:0]);
  endtask

  task automatic hash_transfer(logic [7:0] b, logic has, logic last);
    logic [5:0] pos;
    digest_word_t d;
    if (has) begin
      pos = byte_cnt_q[5:0];
      merge_byte(pos, b);
      byte_cnt_q++;
      if (pos == 6'd63) fold_block();
    end
    if (last) begin
      pos = byte_cnt_q[5:0];
      merge_byte(pos, 8'h80);
      if (pos >= 6'd56) fold_block();
      block_q[14] = '0;
      block_q[15] = {byte_cnt_q, 3'b000};
      fold_block();
      for (int k = 0; k < 8; k++) begin
        d.word = chain_q[k];
        d.idx  = 3'(k);
        d.last = (k == 7);
        digest_exp_q.push_back(d);
      end
      chain_q    = HashIv;
      byte_cnt_q = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t got, want;
    if (!rst_ni) begin
      chain_q    = HashIv;
      for (int t = 0; t < 16; t++) block_q[t] = '0;
      byte_cnt_q = '0;
      digest_exp_q.delete();
      fail_q <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast};
        if (digest_exp_q.size() == 0) begin
          if (fail_q < 10) $display("unexpected digest word %h idx %0d", got.word, got.idx);
          fail_q <= fail_q + 1;
        end else begin
          want = digest_exp_q.pop_front();
          if (got != want || m_axis_tdata[39:35] != '0) begin
            if (fail_q < 10)
              $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b", want.word, want.idx,
                       want.last, got.word, got.idx, got.last);
            fail_q <= fail_q + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        hash_transfer(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
  end
endmodule

/* verif/sha256_stream_hasher_tb.sv */
// Testbench top for the SHA-256 stream hasher: byte stimulus and verdict.
module sha256_stream_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          digest_pending;
  int          n_sent = 0;
  bit          long_hold = 1'b0;  // receiver holds off while set

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sha256_stream_hasher dut (.*);

  sha256_stream_hasher_chk chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count),
    .digest_pending_o(digest_pending));

  // Offer one transfer after a random gap and hold it until accepted.
  task automatic send_byte(logic [7:0] b, logic has, logic last);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= has;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // Send a message of len random bytes; ends either on the last byte or on
  // a separate empty marker.
  task automatic send_msg(int len);
    bit sep;
    sep = (len == 0) || ($urandom_range(0, 2) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom), 1'b0, 1'b0);  // idle transfer
      send_byte(8'($urandom), 1'b1, !sep && i == len - 1);
    end
    if (sep) send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: random stall per word, with one long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty message, byte extremes, pad-boundary lengths.
    send_msg(0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'ha5, 1'b0, 1'b1);
    long_hold = 1'b1;  // receiver stalls while messages keep coming
    send_msg(3);
    send_msg(1);
    send_msg(2);
    send_msg(55); send_msg(56); send_msg(63); send_msg(64);
    while (n_sent < 280) begin
      int len;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
      send_msg(len);
    end
    s_axis_tvalid <= 1'b0;
    while (digest_pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
